### rtl/hsl_to_rgb_converter_defines.svh
// Assertion macros for the HSL to RGB converter checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define HSL_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsl_to_rgb_converter: assertion failed");

// Next-cycle implication, masked while reset is high.
`define HSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsl_to_rgb_converter: assertion failed");

// Next-cycle implication that also holds across reset.
`define HSL_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hsl_to_rgb_converter: assertion failed");

`endif

### rtl/hsl_pkg.sv
// Shared types and constants of the HSL to RGB converter.
// No dependencies.
package hsl_pkg;

  localparam int FRACTION_BITS_DEF = 8;

  localparam int HUE_W  = 9;
  localparam int FRAC_W = 9;
  localparam int CHAN_W = 8;
  localparam int LS_W   = 2 * FRAC_W;

  localparam int NUM_STAGES = 5;

  localparam int HUE_TURN   = 360;
  localparam int HUE_THIRD  = 120;
  localparam int PIECE_RISE = 60;
  localparam int PIECE_HOLD = 180;
  localparam int PIECE_FALL = 240;
  localparam int K_W        = 11;
  localparam int T_W        = 6;

  localparam int CHAN_SHIFT = 8;
  localparam int CHAN_MAX   = (1 << CHAN_SHIFT) - 1;
  localparam int GREY_W     = FRAC_W + CHAN_SHIFT;

  localparam int V_EXTRA = 12;
  localparam int P_EXTRA = 7;
  localparam int N_EXTRA = CHAN_SHIFT + 1;

  localparam int M_LIMIT     = PIECE_RISE * (CHAN_MAX + 1) - 1;
  localparam int QUOT_W      = 14;
  localparam int DIV60_RECIP = 17477;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 20;

  typedef enum logic [1:0] {
    THIRD_NONE,
    THIRD_UP,
    THIRD_DOWN
  } hue_third_t;

  localparam hue_third_t CHAN_THIRD [3] = '{THIRD_UP, THIRD_NONE, THIRD_DOWN};

  typedef struct packed {
    logic scale;
    logic div;
  } hsl_quant_en_t;

endpackage

### rtl/hsl_in_if.sv
// Input channel of the converter: one HSL word per handshake.
// Depends on hsl_pkg.
interface hsl_in_if;
  import hsl_pkg::*;

  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue_degrees;
  logic [FRAC_W-1:0] saturation;
  logic [FRAC_W-1:0] lightness;

  modport source (output valid, output hue_degrees, output saturation, output lightness,
                  input ready);
  modport sink (input valid, input hue_degrees, input saturation, input lightness,
                output ready);
endinterface

### rtl/hsl_out_if.sv
// Output channel of the converter: one RGB word per handshake.
// Depends on hsl_pkg.
interface hsl_out_if;
  import hsl_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/hsl_to_rgb_converter.sv
// HSL to RGB converter, top level. Takes one HSL word per clock unless an output stall has
// filled the pipeline, and returns one RGB word through five register stages: hue weights and
// lightness products, the v1/v2 levels, the per-channel blend, the scale-by-255 clamp, and the divide by 60.
// Every stage has its own valid bit and moves when the stage after it is free, so bubbles
// close up and an output stall only backs up the input once the pipeline is full.
// Zero saturation gives grey, the truncated lightness times 255, on all three channels.
// Depends on hsl_pkg, hsl_in_if, hsl_out_if and the hsl_* submodules.
module hsl_to_rgb_converter #(
  parameter int FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hsl_in_if.sink    pix_in,
  hsl_out_if.source pix_out
);
  import hsl_pkg::*;

  localparam int VW = 2 * FRACTION_BITS + V_EXTRA;
  localparam int PW = VW + P_EXTRA;

  logic [NUM_STAGES:1] vld;
  logic [NUM_STAGES:1] rdy;

  logic [T_W-1:0]        t_next [3];
  logic [LS_W-1:0]       ls_next;
  logic [GREY_W-1:0]     gprod;
  logic [GREY_W-1:0]     gq;
  logic [CHAN_W-1:0]     gval_next;
  logic                  low_next;
  logic                  grey_next;

  logic [T_W-1:0]        s1_t [3];
  logic [FRAC_W-1:0]     s1_l;
  logic [FRAC_W-1:0]     s1_s;
  logic [LS_W-1:0]       s1_ls;
  logic                  s1_low;
  logic                  s1_grey;
  logic [CHAN_W-1:0]     s1_gval;

  logic signed [VW-1:0]  v1_next;
  logic signed [VW-1:0]  v2_next;
  logic signed [VW-1:0]  s2_v1;
  logic signed [VW-1:0]  s2_v2;
  logic [T_W-1:0]        s2_t [3];
  logic                  s2_grey;
  logic [CHAN_W-1:0]     s2_gval;

  logic signed [PW-1:0]  p_next [3];
  logic signed [PW-1:0]  s3_p [3];
  logic                  s3_grey;
  logic [CHAN_W-1:0]     s3_gval;

  logic                  s4_grey;
  logic [CHAN_W-1:0]     s4_gval;
  logic                  s5_grey;
  logic [CHAN_W-1:0]     s5_gval;

  hsl_quant_en_t         quant_en;
  logic [CHAN_W-1:0]     q [3];

  always_comb begin
    rdy[NUM_STAGES] = !vld[NUM_STAGES] || pix_out.ready;
    for (int i = NUM_STAGES - 1; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign pix_in.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= pix_in.valid;
      end
      for (int i = 2; i <= NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_hue
    hsl_hue_piece u_hue (
      .hue_degrees (pix_in.hue_degrees),
      .third       (CHAN_THIRD[ch]),
      .t           (t_next[ch])
    );
  end

  always_comb begin
    ls_next   = pix_in.lightness * pix_in.saturation;
    gprod     = {pix_in.lightness, CHAN_SHIFT'(0)} - GREY_W'(pix_in.lightness);
    gq        = gprod >> FRACTION_BITS;
    gval_next = (gq > GREY_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : gq[CHAN_W-1:0];
    low_next  = (pix_in.lightness >> (FRACTION_BITS - 1)) == '0;
    grey_next = pix_in.saturation == '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_t    <= t_next;
      s1_l    <= pix_in.lightness;
      s1_s    <= pix_in.saturation;
      s1_ls   <= ls_next;
      s1_low  <= low_next;
      s1_grey <= grey_next;
      s1_gval <= gval_next;
    end
  end

  hsl_level #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_level (
    .lightness  (s1_l),
    .saturation (s1_s),
    .ls         (s1_ls),
    .low        (s1_low),
    .v1         (v1_next),
    .v2         (v2_next)
  );

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_v1   <= v1_next;
      s2_v2   <= v2_next;
      s2_t    <= s1_t;
      s2_grey <= s1_grey;
      s2_gval <= s1_gval;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_mix
    hsl_chan_mix #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_mix (
      .v1 (s2_v1),
      .v2 (s2_v2),
      .t  (s2_t[ch]),
      .p  (p_next[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_p    <= p_next;
      s3_grey <= s2_grey;
      s3_gval <= s2_gval;
    end
  end

  assign quant_en.scale = rdy[4];
  assign quant_en.div   = rdy[5];

  for (genvar ch = 0; ch < 3; ch++) begin : g_quant
    hsl_chan_quant #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_quant (
      .clk (clk),
      .en  (quant_en),
      .p   (s3_p[ch]),
      .q   (q[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_grey <= s3_grey;
      s4_gval <= s3_gval;
    end
    if (rdy[5]) begin
      s5_grey <= s4_grey;
      s5_gval <= s4_gval;
    end
  end

  assign pix_out.valid = vld[NUM_STAGES];
  assign pix_out.red   = s5_grey ? s5_gval : q[0];
  assign pix_out.green = s5_grey ? s5_gval : q[1];
  assign pix_out.blue  = s5_grey ? s5_gval : q[2];
endmodule

### rtl/hsl_hue_piece.sv
// Channel hue offset, wrap and piecewise weight for one color channel.
// Depends on hsl_pkg.
module hsl_hue_piece (
  input  logic [hsl_pkg::HUE_W-1:0] hue_degrees,
  input  hsl_pkg::hue_third_t       third,
  output logic [hsl_pkg::T_W-1:0]   t
);
  import hsl_pkg::*;

  logic signed [K_W-1:0] k;
  logic signed [K_W-1:0] kw;

  always_comb begin
    k = $signed({{(K_W-HUE_W){1'b0}}, hue_degrees});
    case (third)
      THIRD_UP:   k = k + K_W'(HUE_THIRD);
      THIRD_DOWN: k = k - K_W'(HUE_THIRD);
      default:    k = k;
    endcase
    kw = k;
    if (k < 0) begin
      kw = k + K_W'(HUE_TURN);
    end else if (k > K_W'(HUE_TURN)) begin
      kw = k - K_W'(HUE_TURN);
    end
    if (kw < K_W'(PIECE_RISE)) begin
      t = kw[T_W-1:0];
    end else if (kw < K_W'(PIECE_HOLD)) begin
      t = T_W'(PIECE_RISE);
    end else if (kw < K_W'(PIECE_FALL)) begin
      t = T_W'(K_W'(PIECE_FALL) - kw);
    end else begin
      t = '0;
    end
  end
endmodule

### rtl/hsl_level.sv
// Two-level values v1 and v2 from lightness and saturation.
// Depends on hsl_pkg.
module hsl_level #(
  parameter int FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEF
) (
  input  logic [hsl_pkg::FRAC_W-1:0]                           lightness,
  input  logic [hsl_pkg::FRAC_W-1:0]                           saturation,
  input  logic [hsl_pkg::LS_W-1:0]                             ls,
  input  logic                                                 low,
  output logic signed [2*FRACTION_BITS+hsl_pkg::V_EXTRA-1:0]   v1,
  output logic signed [2*FRACTION_BITS+hsl_pkg::V_EXTRA-1:0]   v2
);
  import hsl_pkg::*;

  localparam int VW = 2 * FRACTION_BITS + V_EXTRA;

  logic signed [VW-1:0] lone;
  logic signed [VW-1:0] sone;
  logic signed [VW-1:0] lsx;

  assign lone = VW'(lightness) << FRACTION_BITS;
  assign sone = VW'(saturation) << FRACTION_BITS;
  assign lsx  = VW'(ls);

  always_comb begin
    if (low) begin
      v2 = lone + lsx;
    end else begin
      v2 = lone + sone - lsx;
    end
    v1 = (lone <<< 1) - v2;
  end
endmodule

### rtl/hsl_chan_mix.sv
// Weighted blend of v1 and v2 by the channel hue weight.
// Depends on hsl_pkg.
module hsl_chan_mix #(
  parameter int FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEF
) (
  input  logic signed [2*FRACTION_BITS+hsl_pkg::V_EXTRA-1:0]                  v1,
  input  logic signed [2*FRACTION_BITS+hsl_pkg::V_EXTRA-1:0]                  v2,
  input  logic [hsl_pkg::T_W-1:0]                                             t,
  output logic signed [2*FRACTION_BITS+hsl_pkg::V_EXTRA+hsl_pkg::P_EXTRA-1:0] p
);
  import hsl_pkg::*;

  localparam int PW = 2 * FRACTION_BITS + V_EXTRA + P_EXTRA;

  logic signed [T_W+1:0] tw;
  logic signed [T_W+1:0] tc;
  logic signed [PW-1:0]  a;
  logic signed [PW-1:0]  b;

  always_comb begin
    tw = $signed({2'b00, t});
    tc = (T_W+2)'(PIECE_RISE) - tw;
    a  = v1 * tc;
    b  = v2 * tw;
    p  = a + b;
  end
endmodule

### rtl/hsl_chan_quant.sv
// Two-stage scale by 255, clamp and divide by 60 of one channel.
// Depends on hsl_pkg.
module hsl_chan_quant #(
  parameter int FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEF
) (
  input  logic                                                                clk,
  input  hsl_pkg::hsl_quant_en_t                                              en,
  input  logic signed [2*FRACTION_BITS+hsl_pkg::V_EXTRA+hsl_pkg::P_EXTRA-1:0] p,
  output logic [hsl_pkg::CHAN_W-1:0]                                          q
);
  import hsl_pkg::*;

  localparam int PW = 2 * FRACTION_BITS + V_EXTRA + P_EXTRA;
  localparam int NW = PW + N_EXTRA;
  localparam int MW = NW - 2 * FRACTION_BITS;

  logic signed [NW-1:0]          n;
  logic signed [MW-1:0]          mw;
  logic [QUOT_W-1:0]             m_next;
  logic [QUOT_W-1:0]             m;
  logic [QUOT_W+RECIP_W-1:0]     prod;

  always_comb begin
    n  = (NW'(p) <<< CHAN_SHIFT) - NW'(p);
    mw = n[NW-1:2*FRACTION_BITS];
    if (n <= 0) begin
      m_next = '0;
    end else if (mw > MW'(M_LIMIT)) begin
      m_next = QUOT_W'(M_LIMIT);
    end else begin
      m_next = mw[QUOT_W-1:0];
    end
  end

  assign prod = m * RECIP_W'(DIV60_RECIP);

  always_ff @(posedge clk) begin
    if (en.scale) begin
      m <= m_next;
    end
    if (en.div) begin
      q <= prod[RECIP_SHIFT +: CHAN_W];
    end
  end
endmodule

### rtl/hsl_to_rgb_checker.sv
// Port-level checker for the HSL to RGB converter, bound to the top level.
// Depends on hsl_pkg and hsl_to_rgb_converter_defines.svh.
`include "hsl_to_rgb_converter_defines.svh"

module hsl_to_rgb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hsl_pkg::CHAN_W-1:0] red,
  input logic [hsl_pkg::CHAN_W-1:0] green,
  input logic [hsl_pkg::CHAN_W-1:0] blue
);
  import hsl_pkg::*;

  logic out_free;

  assign out_free = !out_valid || out_ready;

  `HSL_ASSERT_NEXT_ALWAYS(a_reset_drains, rst, !out_valid)
  `HSL_ASSERT_IMPLIES(a_free_output_takes_input, out_free, in_ready)
  `HSL_ASSERT_NEXT(a_stall_holds_valid, out_valid && !out_ready, out_valid)
  `HSL_ASSERT_NEXT(a_stall_holds_word, out_valid && !out_ready, $stable({red, green, blue}))

endmodule

bind hsl_to_rgb_converter hsl_to_rgb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .red       (pix_out.red),
  .green     (pix_out.green),
  .blue      (pix_out.blue)
);
